FILE: rtl/dmhq_pkg.sv
package dmhq_pkg;
   localparam int ValueWidth = 32;
   localparam int OccWidth = 11;
   localparam logic ActInsert = 1'b0;
   localparam logic ActExtract = 1'b1;
   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;
endpackage

FILE: rtl/dmhq_ram.sv
module dmhq_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/dary_min_heap_queue.sv
// d-ary min-heap priority queue on one single-port-read memory.
// Request channel: req_valid/req_stall with req_action (0 insert, 1 extract)
// and req_item_value. Response channel: rsp_valid/rsp_stall with
// rsp_result_value, rsp_status and rsp_occupancy; one response per request.
// One request is worked at a time; req_stall is high while busy or while
// a response waits. Steps from the accepting edge to rsp_valid high:
// insert writes the key at the end, then per level compared reads the parent
// and compares/writes, with a final write when the key climbs to the root;
// extract reads the root and the last key, then per level examined issues
// and compares child reads one at a time and writes the swap. All reads
// share the single memory read port. An empty/full reject and an insert
// into an empty heap go straight to the response.
// The response is held in an output register until taken; the next request
// is taken at the edge after the response leaves. Synchronous active-high
// reset empties the heap (count to zero); memory contents are not cleared
// since only slots below the count are ever read.
module dary_min_heap_queue #(
   parameter int CAPACITY = 1024,
   parameter int ARITY = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic signed [dmhq_pkg::ValueWidth-1:0] req_item_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [dmhq_pkg::ValueWidth-1:0] rsp_result_value,
   output logic [1:0]                           rsp_status,
   output logic [dmhq_pkg::OccWidth-1:0]        rsp_occupancy
);
   import dmhq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = CW + 4;   // wide enough for pos*ARITY+ARITY
   localparam int KW = $clog2(ARITY + 1);
   // (pos-1)/ARITY by reciprocal multiply, exact for operands below 2**PW
   localparam int DivShift = PW + $clog2(ARITY);
   localparam int ProdW = 2 * PW + 4;
   localparam logic [PW:0] DivMul =
      (PW+1)'(((64'd1 << DivShift) + 64'(ARITY) - 64'd1) / 64'(ARITY));

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_UP_RD = 4'd1;   // read parent
   localparam logic [3:0] S_UP_CMP = 4'd2;
   localparam logic [3:0] S_EX_RD = 4'd3;   // read last key
   localparam logic [3:0] S_EX_WR = 4'd4;
   localparam logic [3:0] S_DN_RD = 4'd5;   // issue child reads
   localparam logic [3:0] S_DN_CMP = 4'd6;
   localparam logic [3:0] S_RSP = 4'd7;
   localparam logic [3:0] S_EX_ROOT = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] pos_ff, pos_in;        // current node (0-based)
   logic [PW-1:0] best_ff, best_in;
   logic [PW-1:0] child_ff, child_in;    // child whose data returns next
   logic [KW-1:0] k_ff, k_in;
   logic          rd_pend_ff, rd_pend_in;
   logic signed [ValueWidth-1:0] key_ff, key_in;    // key being sifted
   logic signed [ValueWidth-1:0] bestv_ff, bestv_in;
   logic signed [ValueWidth-1:0] res_ff, res_in;
   logic [1:0] stat_ff, stat_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [ValueWidth-1:0] wr_data, rd_data;
   logic signed [ValueWidth-1:0] rd_val;
   logic [PW-1:0] parent, first;
   logic [ProdW-1:0] parent_prod;
   logic accept, rsp_take;

   dmhq_ram #(.Width(ValueWidth), .Depth(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_val = signed'(rd_data);
   assign parent_prod = ProdW'(pos_ff - PW'(1)) * ProdW'(DivMul);
   assign parent = parent_prod[DivShift +: PW];
   assign first = pos_ff * PW'(ARITY) + PW'(1);
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      best_in = best_ff;
      child_in = child_ff;
      k_in = k_ff;
      rd_pend_in = 1'b0;
      key_in = key_ff;
      bestv_in = bestv_ff;
      res_in = res_ff;
      stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = key_ff;
      rd_addr = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in = '0;
               stat_in = STATUS_OK;
               if (req_action == ActInsert) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     stat_in = STATUS_FULL;
                     state_in = S_RSP;
                  end else begin
                     wr_en = 1'b1;
                     wr_addr = count_ff[AW-1:0];
                     wr_data = req_item_value;
                     key_in = req_item_value;
                     pos_in = PW'(count_ff);
                     count_in = count_ff + CW'(1);
                     state_in = (count_ff == '0) ? S_RSP : S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     stat_in = STATUS_EMPTY;
                     state_in = S_RSP;
                  end else begin
                     rd_addr = '0;
                     count_in = count_ff - CW'(1);
                     state_in = S_EX_ROOT;
                  end
               end
            end
         end
         S_UP_RD: begin
            rd_addr = parent[AW-1:0];
            best_in = parent;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            if (rd_val <= key_ff) begin
               // key settles here
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = key_ff;
               state_in = S_RSP;
            end else begin
               // move parent down; key goes on up
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = rd_val;
               pos_in = best_ff;
               if (best_ff == '0) begin
                  state_in = S_EX_WR;   // final write of key at root
               end else begin
                  state_in = S_UP_RD;
               end
            end
         end
         S_EX_ROOT: begin
            res_in = rd_val;
            rd_addr = count_ff[AW-1:0];
            state_in = S_EX_RD;
         end
         S_EX_RD: begin
            key_in = rd_val;
            pos_in = '0;
            state_in = S_DN_RD;
            k_in = '0;
         end
         S_EX_WR: begin
            wr_en = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_data = key_ff;
            state_in = S_RSP;
         end
         S_DN_RD: begin
            // issue one child read per cycle, compare the previous one
            if (rd_pend_ff) begin
               if (k_ff == KW'(1) || rd_val < bestv_ff) begin
                  bestv_in = rd_val;
                  best_in = child_ff;
               end
            end
            if (k_ff == '0 && first >= PW'(count_ff)) begin
               state_in = S_EX_WR;
            end else if (k_ff < KW'(ARITY) && (first + PW'(k_ff)) < PW'(count_ff)) begin
               rd_addr = AW'(first + PW'(k_ff));
               child_in = first + PW'(k_ff);
               rd_pend_in = 1'b1;
               k_in = k_ff + KW'(1);
            end else begin
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            k_in = '0;
            if (key_ff <= bestv_ff) begin
               state_in = S_EX_WR;
            end else begin
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = bestv_ff;
               pos_in = best_ff;
               state_in = S_DN_RD;
            end
         end
         S_RSP: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff <= rd_pend_in;
         k_ff <= k_in;
      end
      pos_ff <= pos_in;
      best_ff <= best_in;
      child_ff <= child_in;
      key_ff <= key_in;
      bestv_ff <= bestv_in;
      res_ff <= res_in;
      stat_ff <= stat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_status = stat_ff;
   assign rsp_occupancy = OccWidth'(count_ff);

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count over capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !accept) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(res_ff))
      else $error("response dropped");
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (PW'(wr_addr) < PW'(CAPACITY))) else $error("write out of range");
`endif
endmodule
